FILE: sv/keepalive_session_table_macros.svh
// ----------------------------------------------------------------------------
// keepalive_session_table_macros.svh
// assertion shorthands for the session table checkers
// ----------------------------------------------------------------------------
`ifndef KEEPALIVE_SESSION_TABLE_MACROS_SVH
`define KEEPALIVE_SESSION_TABLE_MACROS_SVH

// same-cycle implication, sampled on clk, quiet while rst is high
`define KST_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keepalive_session_table check failed");

// next-cycle implication, sampled on clk, quiet while rst is high
`define KST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keepalive_session_table check failed");

`endif

FILE: sv/kst_pkg.sv
// ----------------------------------------------------------------------------
// kst_pkg
// shared types and codes of the keepalive session table
// ----------------------------------------------------------------------------
`default_nettype none

package kst_pkg;

  // input event codes
  localparam logic [2:0] ACT_CONNECT    = 3'd0;
  localparam logic [2:0] ACT_DISCONNECT = 3'd1;
  localparam logic [2:0] ACT_PONG       = 3'd2;
  localparam logic [2:0] ACT_DEVINFO    = 3'd3;
  localparam logic [2:0] ACT_TICK       = 3'd4;

  // result kinds
  localparam logic [3:0] KIND_PING       = 4'd0;
  localparam logic [3:0] KIND_EXPIRED    = 4'd1;
  localparam logic [3:0] KIND_DISC       = 4'd2;
  localparam logic [3:0] KIND_PONG_OK    = 4'd3;
  localparam logic [3:0] KIND_PONG_UNEXP = 4'd4;
  localparam logic [3:0] KIND_DEVINFO    = 4'd5;
  localparam logic [3:0] KIND_REPEAT     = 4'd6;
  localparam logic [3:0] KIND_NOTCONN    = 4'd7;
  localparam logic [3:0] KIND_SWEEP      = 4'd8;
  localparam logic [3:0] KIND_FULL       = 4'd9;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_PING_WAIT     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PING_INTERVAL = 8'd1;

  localparam logic [31:0] RESET_WAIT_MS     = 32'd10000;
  localparam logic [31:0] RESET_INTERVAL_MS = 32'd10000;

  // one table entry: pong flag and time of the last ping
  typedef struct packed {
    logic        pong_seen;
    logic [31:0] ping_time;
  } entry_t;

  // one result beat from the sequencer to the output stage
  typedef struct packed {
    logic       valid;
    logic [3:0] kind;
    logic [4:0] slot;
    logic       last;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVENT,
    ST_SWEEP,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: sv/kst_mem.sv
// ----------------------------------------------------------------------------
// kst_mem
// session entry store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module kst_mem #(
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5
) (
  input  wire                    clk,
  input  wire                    wr_en,
  input  wire [ADDR_W-1:0]       wr_addr,
  input  kst_pkg::entry_t        wr_data,
  input  wire                    rd_en,
  input  wire [ADDR_W-1:0]       rd_addr,
  output kst_pkg::entry_t        rd_data
);

  kst_pkg::entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/kst_ctrl.sv
// ----------------------------------------------------------------------------
// kst_ctrl
// event sequencer: reads an entry, decides the result, writes it back
// ----------------------------------------------------------------------------
`default_nettype none

module kst_ctrl #(
  parameter int MAX_SESSIONS = 32,
  parameter int IDX_W        = 5
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire [2:0]         in_action,
  input  wire [4:0]         in_client_id,
  input  wire [31:0]        in_now,
  input  wire [31:0]        wait_limit,
  input  wire [31:0]        ping_gap,
  output logic              rd_en,
  output logic [IDX_W-1:0]  rd_addr,
  input  kst_pkg::entry_t   rd_data,
  output logic              wr_en,
  output logic [IDX_W-1:0]  wr_addr,
  output kst_pkg::entry_t   wr_data,
  output kst_pkg::res_t     res,
  input  wire               res_ready
);

  localparam logic [5:0]       NUM_SLOTS = 6'(MAX_SESSIONS);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(MAX_SESSIONS - 1);

  kst_pkg::state_t           state, state_next;
  logic [2:0]                action;
  logic [4:0]                client_id;
  logic [31:0]               now;
  logic [IDX_W-1:0]          cur, cur_next;
  logic [MAX_SESSIONS-1:0]   slot_live, slot_live_next;

  logic                      accept;
  logic                      in_id_ok;
  logic                      id_ok;
  logic [IDX_W-1:0]          id_idx;
  logic                      live_ev;
  logic                      live_sw;
  logic [31:0]               age;
  logic                      wait_over;
  logic                      interval_over;

  assign in_ready  = (state == kst_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign in_id_ok  = ({1'b0, in_client_id} < NUM_SLOTS);
  assign id_ok     = ({1'b0, client_id} < NUM_SLOTS);
  assign id_idx    = client_id[IDX_W-1:0];
  assign live_ev   = id_ok && slot_live[id_idx];
  assign live_sw   = slot_live[cur];

  // wrapping age of the last ping
  assign age           = now - rd_data.ping_time;
  assign wait_over     = (age > wait_limit);
  assign interval_over = (age > ping_gap);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kst_pkg::ST_IDLE;
      slot_live <= '0;
    end else begin
      state     <= state_next;
      slot_live <= slot_live_next;
    end
  end

  // item and sweep position
  always_ff @(posedge clk) begin
    if (accept) begin
      action    <= in_action;
      client_id <= in_client_id;
      now       <= in_now;
    end
    cur <= cur_next;
  end

  // next state, memory accesses and result
  always_comb begin
    state_next     = state;
    cur_next       = cur;
    slot_live_next = slot_live;
    rd_en          = 1'b0;
    rd_addr        = cur;
    wr_en          = 1'b0;
    wr_addr        = cur;
    wr_data        = '{pong_seen: 1'b0, ping_time: now};
    res            = '0;

    unique case (state)
      kst_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_action == kst_pkg::ACT_TICK) begin
            rd_en      = 1'b1;
            rd_addr    = '0;
            cur_next   = '0;
            state_next = kst_pkg::ST_SWEEP;
          end else begin
            rd_en      = in_id_ok;
            rd_addr    = in_client_id[IDX_W-1:0];
            state_next = kst_pkg::ST_EVENT;
          end
        end
      end

      kst_pkg::ST_EVENT: begin
        res.slot = client_id;
        res.last = 1'b1;
        wr_addr  = id_idx;
        unique case (action)
          kst_pkg::ACT_CONNECT: begin
            res.valid = 1'b1;
            if (!id_ok) begin
              res.kind = kst_pkg::KIND_FULL;
            end else if (live_ev) begin
              res.kind = kst_pkg::KIND_REPEAT;
            end else begin
              res.kind = kst_pkg::KIND_PING;
              if (res_ready) begin
                wr_en                  = 1'b1;
                slot_live_next[id_idx] = 1'b1;
              end
            end
          end
          kst_pkg::ACT_DISCONNECT: begin
            res.valid = 1'b1;
            res.kind  = live_ev ? kst_pkg::KIND_DISC : kst_pkg::KIND_NOTCONN;
            if (res_ready && live_ev) begin
              slot_live_next[id_idx] = 1'b0;
            end
          end
          kst_pkg::ACT_PONG: begin
            res.valid = 1'b1;
            if (live_ev) begin
              res.kind = rd_data.pong_seen ? kst_pkg::KIND_PONG_UNEXP
                                           : kst_pkg::KIND_PONG_OK;
              wr_en    = res_ready;
              wr_data  = '{pong_seen: 1'b1, ping_time: rd_data.ping_time};
            end else begin
              res.kind = kst_pkg::KIND_NOTCONN;
            end
          end
          kst_pkg::ACT_DEVINFO: begin
            res.valid = 1'b1;
            res.kind  = live_ev ? kst_pkg::KIND_DEVINFO : kst_pkg::KIND_NOTCONN;
          end
          default: begin
            res.valid = 1'b0;
          end
        endcase
        if (!res.valid || res_ready) begin
          state_next = kst_pkg::ST_IDLE;
        end
      end

      kst_pkg::ST_SWEEP: begin
        res.slot = 5'(cur);
        res.last = 1'b0;
        // unanswered ping past the wait limit, or pong back and interval gone
        if (live_sw && !rd_data.pong_seen && wait_over) begin
          res.valid = 1'b1;
          res.kind  = kst_pkg::KIND_EXPIRED;
          if (res_ready) begin
            slot_live_next[cur] = 1'b0;
          end
        end else if (live_sw && rd_data.pong_seen && interval_over) begin
          res.valid = 1'b1;
          res.kind  = kst_pkg::KIND_PING;
          wr_en     = res_ready;
        end
        // move on to the next slot, reading it ahead
        if (!res.valid || res_ready) begin
          if (cur == LAST_IDX) begin
            state_next = kst_pkg::ST_DONE;
          end else begin
            cur_next = cur + 1'b1;
            rd_en    = 1'b1;
            rd_addr  = cur + 1'b1;
          end
        end
      end

      kst_pkg::ST_DONE: begin
        res.valid = 1'b1;
        res.kind  = kst_pkg::KIND_SWEEP;
        res.slot  = '0;
        res.last  = 1'b1;
        if (res_ready) begin
          state_next = kst_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = kst_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/kst_out.sv
// ----------------------------------------------------------------------------
// kst_out
// output register for result beats
// ----------------------------------------------------------------------------
`default_nettype none

module kst_out (
  input  wire            clk,
  input  wire            rst,
  input  kst_pkg::res_t  res,
  output logic           res_ready,
  output logic           m_tvalid,
  input  wire            m_tready,
  output logic [7:0]     m_tdata,
  output logic [3:0]     m_tuser,
  output logic           m_tlast
);

  logic [4:0] slot;

  assign res_ready = !m_tvalid || m_tready;
  assign m_tdata   = {3'b000, slot};

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res.valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      slot    <= res.slot;
      m_tuser <= res.kind;
      m_tlast <= res.last;
    end
  end

endmodule

`default_nettype wire

FILE: sv/keepalive_session_table.sv
// ----------------------------------------------------------------------------
// keepalive_session_table
// ping/pong session table with timer sweep, on stream channels
// ----------------------------------------------------------------------------
// Events come in on the s_ channel: tuser is the event code, tdata carries the
// client slot and the current time in ms. Results leave on the m_ channel:
// tuser is the result kind, tdata the slot, tlast marks the final result of
// an event. Timing registers are written through the cfg_ channel, which is
// always ready; write them only while no event is in flight.
// A control event reads the slot entry from the table memory in its accept
// cycle; the sequencer then places the single result in the output register.
// A timer tick visits every slot in order, one slot per cycle while the
// output register takes results, the read of the next slot overlapping the
// check and write-back of the current one, then gives the sweep-done beat.
// The single table memory port pair sets this pace.
// Reset empties the table and loads both timing registers with 10000 ms; the
// memory needs no clearing, as an entry is only used once its slot is live.
// When m_tready is low the sequence holds in place until the output register
// drains; no result is dropped and s_tready stays low meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module keepalive_session_table #(
  parameter int MAX_SESSIONS = 32
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            s_tvalid,
  output logic                           s_tready,
  input  wire [39:0]                     s_tdata,   // client_id[4:0], now_ms[36:5]
  input  wire [2:0]                      s_tuser,   // action[2:0]
  output logic                           m_tvalid,
  input  wire                            m_tready,
  output logic [7:0]                     m_tdata,   // slot[4:0]
  output logic [3:0]                     m_tuser,   // kind[3:0]
  output logic                           m_tlast,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire [kst_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [31:0]                     cfg_data
);

  localparam int IDX_W = (MAX_SESSIONS > 1) ? $clog2(MAX_SESSIONS) : 1;

  logic [31:0]        wait_limit;
  logic [31:0]        ping_gap;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  kst_pkg::entry_t    rd_data;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  kst_pkg::entry_t    wr_data;
  kst_pkg::res_t      res;
  logic               res_ready;

  assign cfg_ready = 1'b1;

  // timing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wait_limit <= kst_pkg::RESET_WAIT_MS;
      ping_gap   <= kst_pkg::RESET_INTERVAL_MS;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == kst_pkg::CFG_PING_WAIT) begin
        wait_limit <= cfg_data;
      end else if (cfg_index == kst_pkg::CFG_PING_INTERVAL) begin
        ping_gap <= cfg_data;
      end
    end
  end

  kst_ctrl #(
    .MAX_SESSIONS (MAX_SESSIONS),
    .IDX_W        (IDX_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_action    (s_tuser),
    .in_client_id (s_tdata[4:0]),
    .in_now       (s_tdata[36:5]),
    .wait_limit   (wait_limit),
    .ping_gap     (ping_gap),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .res          (res),
    .res_ready    (res_ready)
  );

  kst_mem #(
    .DEPTH  (MAX_SESSIONS),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  kst_out u_out (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .res_ready (res_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire

FILE: sv/kst_checker.sv
// ----------------------------------------------------------------------------
// kst_checker
// port-level checks of the session table, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "keepalive_session_table_macros.svh"

module kst_port_props (
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [7:0]  m_tdata,
  input wire [3:0]  m_tuser,
  input wire        m_tlast
);

  // a stalled result beat holds
  `KST_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tdata, m_tuser, m_tlast}))

  // one event at a time: the input closes after each beat
  `KST_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)

  // sweep done closes a tick and names slot zero
  `KST_ASSERT_SAME(a_sweep_end, m_tvalid && (m_tuser == kst_pkg::KIND_SWEEP), m_tlast && (m_tdata == 8'd0))

  // only sweep pings and expiries come before the final beat
  `KST_ASSERT_SAME(a_mid_kind, m_tvalid && !m_tlast, (m_tuser == kst_pkg::KIND_PING) || (m_tuser == kst_pkg::KIND_EXPIRED))

endmodule

bind keepalive_session_table kst_port_props u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

FILE: verif/kst_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kst_checker
// scoreboard for the keepalive session table
// ----------------------------------------------------------------------------
// Watches the event, result and register channels at the rising edge. Every
// accepted event goes through a local copy of the session table that works
// out the result beats it must cause. Result beats are compared in order
// with those expectations.
// ----------------------------------------------------------------------------

module kst_checker #(
  parameter int MAX_SESSIONS = 32
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          s_tvalid,
  input  wire                          s_tready,
  input  wire [39:0]                   s_tdata,   // client_id[4:0], now_ms[36:5]
  input  wire [2:0]                    s_tuser,   // action[2:0]
  input  wire                          m_tvalid,
  input  wire                          m_tready,
  input  wire [7:0]                    m_tdata,   // slot[4:0]
  input  wire [3:0]                    m_tuser,   // kind[3:0]
  input  wire                          m_tlast,
  input  wire                          cfg_valid,
  input  wire                          cfg_ready,
  input  wire [kst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [31:0]                   cfg_data,
  output int                           errors,
  output int                           outstanding,
  output int                           beats_checked
);

  typedef struct packed {
    logic [3:0] kind;
    logic [4:0] slot;
    logic       last;
  } session_result_t;

  // local image of the table and of the timing registers
  logic [31:0] wait_limit;
  logic [31:0] ping_gap;
  bit          live [32];
  bit          pong_back [32];
  logic [31:0] ping_time [32];

  session_result_t awaited_results [$];

  // works out the result beats of one event and moves the table along
  task automatic predict_session_event(input logic [2:0] action, input logic [4:0] id,
                                       input logic [31:0] now);
    session_result_t batch [$];
    logic [31:0]     age;
    logic [3:0]      kind;
    bit              in_table;
    bit              is_live;
    in_table = int'(id) < MAX_SESSIONS;
    is_live  = in_table && live[id];
    case (action)
      kst_pkg::ACT_CONNECT: begin
        if (!in_table) begin
          batch.push_back(session_result_t'{kst_pkg::KIND_FULL, id, 1'b0});
        end else if (is_live) begin
          batch.push_back(session_result_t'{kst_pkg::KIND_REPEAT, id, 1'b0});
        end else begin
          live[id]      = 1'b1;
          ping_time[id] = now;
          pong_back[id] = 1'b0;
          batch.push_back(session_result_t'{kst_pkg::KIND_PING, id, 1'b0});
        end
      end
      kst_pkg::ACT_DISCONNECT: begin
        if (is_live) begin
          live[id] = 1'b0;
          batch.push_back(session_result_t'{kst_pkg::KIND_DISC, id, 1'b0});
        end else begin
          batch.push_back(session_result_t'{kst_pkg::KIND_NOTCONN, id, 1'b0});
        end
      end
      kst_pkg::ACT_PONG: begin
        if (is_live) begin
          kind = pong_back[id] ? kst_pkg::KIND_PONG_UNEXP : kst_pkg::KIND_PONG_OK;
          batch.push_back(session_result_t'{kind, id, 1'b0});
          pong_back[id] = 1'b1;
        end else begin
          batch.push_back(session_result_t'{kst_pkg::KIND_NOTCONN, id, 1'b0});
        end
      end
      kst_pkg::ACT_DEVINFO: begin
        kind = is_live ? kst_pkg::KIND_DEVINFO : kst_pkg::KIND_NOTCONN;
        batch.push_back(session_result_t'{kind, id, 1'b0});
      end
      kst_pkg::ACT_TICK: begin
        // sweep live slots in ascending order, wrapping age compare
        for (int s = 0; s < MAX_SESSIONS && s < 32; s++) begin
          if (live[s]) begin
            age = now - ping_time[s];
            if (!pong_back[s]) begin
              if (age > wait_limit) begin
                live[s] = 1'b0;
                batch.push_back(session_result_t'{kst_pkg::KIND_EXPIRED, 5'(s), 1'b0});
              end
            end else if (age > ping_gap) begin
              ping_time[s] = now;
              pong_back[s] = 1'b0;
              batch.push_back(session_result_t'{kst_pkg::KIND_PING, 5'(s), 1'b0});
            end
          end
        end
        batch.push_back(session_result_t'{kst_pkg::KIND_SWEEP, 5'd0, 1'b0});
      end
      default: ;
    endcase
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) awaited_results.push_back(batch[i]);
  endtask

  // compares one result beat with the oldest expectation
  task automatic check_result_beat();
    session_result_t want;
    if (awaited_results.size() == 0) begin
      $error("result beat with nothing expected: kind %0d slot %0d last %0d",
             m_tuser, m_tdata, m_tlast);
      errors++;
    end else begin
      want = awaited_results.pop_front();
      if (m_tuser !== want.kind) begin
        $error("kind mismatch: expected %0d, actual %0d", want.kind, m_tuser);
        errors++;
      end
      if (m_tdata !== {3'b000, want.slot}) begin
        $error("slot mismatch: expected %0d, actual %0d", want.slot, m_tdata);
        errors++;
      end
      if (m_tlast !== want.last) begin
        $error("last mismatch: expected %0d, actual %0d", want.last, m_tlast);
        errors++;
      end
    end
    beats_checked++;
  endtask

  initial begin
    errors        = 0;
    outstanding   = 0;
    beats_checked = 0;
  end

  // sample all three channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      wait_limit = kst_pkg::RESET_WAIT_MS;
      ping_gap   = kst_pkg::RESET_INTERVAL_MS;
      for (int s = 0; s < 32; s++) begin
        live[s]      = 1'b0;
        pong_back[s] = 1'b1;
        ping_time[s] = '0;
      end
      awaited_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == kst_pkg::CFG_PING_WAIT) wait_limit = cfg_data;
        else if (cfg_index == kst_pkg::CFG_PING_INTERVAL) ping_gap = cfg_data;
      end
      if (s_tvalid && s_tready) predict_session_event(s_tuser, s_tdata[4:0], s_tdata[36:5]);
      if (m_tvalid && m_tready) check_result_beat();
    end
    outstanding = awaited_results.size();
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the keepalive session table
// ----------------------------------------------------------------------------
// Drives session events on the input stream with random gaps, drains results
// with random stalls and steps the timing registers through several settings
// between phases, the extremes among them. A directed opening covers every
// event against free and live slots, wrapping time and ignored codes; random
// phases follow. The checker does all prediction and comparison.
// ----------------------------------------------------------------------------

module tb_top;

  // event codes the block ignores, and register indexes beyond the list
  localparam logic [2:0]                    ACT_RESERVED_FIRST = 3'd5;
  localparam logic [2:0]                    ACT_RESERVED_LAST  = 3'd7;
  localparam logic [kst_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE      = 8'd2;
  localparam logic [kst_pkg::CFG_IDX_W-1:0] CFG_IDX_TOP        = 8'hFF;
  localparam int                            DRAIN_CYCLES       = 40;

  logic                          clk;
  logic                          rst;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [39:0]                   s_tdata;   // client_id[4:0], now_ms[36:5]
  logic [2:0]                    s_tuser;   // action[2:0]
  logic                          m_tvalid;
  logic                          m_tready;
  logic [7:0]                    m_tdata;   // slot[4:0]
  logic [3:0]                    m_tuser;   // kind[3:0]
  logic                          m_tlast;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [kst_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0]                   cfg_data;

  int          errors;
  int          outstanding;
  int          beats_checked;
  int          events_sent;
  int          sweeps_sent;
  int          settings_used;
  bit          tx_steady;
  bit          rx_steady;
  logic [31:0] clock_ms;

  keepalive_session_table #(.MAX_SESSIONS(32)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  kst_checker #(.MAX_SESSIONS(32)) u_scoreboard (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .outstanding(outstanding), .beats_checked(beats_checked)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("[keepalive_session_table] ERROR");
    $finish;
  end

  // result side: random stall per beat, with stall-free stretches
  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_steady = ~rx_steady;
      stall = rx_steady ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      @(negedge clk);
    end
  end

  // one event beat; entered and left at a falling edge
  task automatic send_event(input logic [2:0] action, input logic [4:0] id,
                            input logic [31:0] now);
    int gap;
    if ($urandom_range(0, 11) == 0) tx_steady = ~tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tuser  = action;
    s_tdata  = {3'b000, now, id};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    @(negedge clk);
    events_sent++;
    if (action == kst_pkg::ACT_TICK) sweeps_sent++;
  endtask

  // one register beat
  task automatic write_reg(input logic [kst_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_index = idx;
    cfg_data  = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // let every expected result drain, then the tail of the block's latency
  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // idle the block and load a new timing setting
  task automatic set_timing(input logic [31:0] wait_ms, input logic [31:0] gap_ms);
    wait_drained();
    write_reg(kst_pkg::CFG_PING_WAIT, wait_ms);
    write_reg(kst_pkg::CFG_PING_INTERVAL, gap_ms);
    settings_used++;
  endtask

  // random events around a few busy slots, time creeping by up to step_max
  task automatic run_random(input int count, input logic [31:0] step_max);
    int          done;
    int          pick;
    logic [2:0]  action;
    logic [4:0]  id;
    done = 0;
    while (done < count) begin
      if ($urandom_range(0, 24) == 0) clock_ms = $urandom();
      else clock_ms = clock_ms + $urandom_range(0, step_max);
      id   = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 7)) : 5'($urandom_range(0, 31));
      pick = $urandom_range(0, 99);
      if (pick < 26) action = kst_pkg::ACT_CONNECT;
      else if (pick < 46) action = kst_pkg::ACT_PONG;
      else if (pick < 66) action = kst_pkg::ACT_TICK;
      else if (pick < 78) action = kst_pkg::ACT_DISCONNECT;
      else if (pick < 94) action = kst_pkg::ACT_DEVINFO;
      else action = 3'($urandom_range(ACT_RESERVED_FIRST, ACT_RESERVED_LAST));
      send_event(action, id, clock_ms);
      if (action <= kst_pkg::ACT_TICK) done++;
    end
  endtask

  // stimulus and verdict
  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = kst_pkg::ACT_CONNECT;
    cfg_valid   = 1'b0;
    cfg_index   = kst_pkg::CFG_PING_WAIT;
    cfg_data    = '0;
    events_sent = 0;
    sweeps_sent = 0;
    settings_used = 1;
    tx_steady   = 1'b0;
    rx_steady   = 1'b0;
    clock_ms    = 32'd20000;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed, reset timing of 10000 ms
    send_event(kst_pkg::ACT_TICK, 5'd0, 32'd0);              // empty table, sweep only
    send_event(kst_pkg::ACT_PONG, 5'd0, 32'd1);              // not connected
    send_event(kst_pkg::ACT_DISCONNECT, 5'd31, 32'd2);
    send_event(kst_pkg::ACT_DEVINFO, 5'd31, 32'd3);
    send_event(kst_pkg::ACT_CONNECT, 5'd0, 32'h0000_0000);
    send_event(kst_pkg::ACT_CONNECT, 5'd31, 32'hFFFF_FFFF);
    send_event(kst_pkg::ACT_CONNECT, 5'd0, 32'd5);           // repeated connect
    send_event(kst_pkg::ACT_DEVINFO, 5'd0, 32'd6);
    send_event(kst_pkg::ACT_PONG, 5'd0, 32'd7);              // awaited pong
    send_event(kst_pkg::ACT_PONG, 5'd0, 32'd8);              // unexpected pong
    send_event(kst_pkg::ACT_TICK, 5'd31, 32'd9999);          // age of 31 at the limit, age of 0 just below
    send_event(kst_pkg::ACT_TICK, 5'd0, 32'd10001);          // re-ping 0, expire 31
    send_event(kst_pkg::ACT_PONG, 5'd31, 32'd10002);
    for (int a = ACT_RESERVED_FIRST; a <= ACT_RESERVED_LAST; a++)
      send_event(3'(a), 5'(a), 32'hA5A5_5A5A);               // ignored codes
    send_event(kst_pkg::ACT_DISCONNECT, 5'd0, 32'd10003);
    send_event(kst_pkg::ACT_DISCONNECT, 5'd0, 32'd10004);
    send_event(kst_pkg::ACT_CONNECT, 5'd7, 32'hFFFF_FFF0);
    send_event(kst_pkg::ACT_TICK, 5'd7, 32'd10);             // wrapped age, nothing due
    send_event(kst_pkg::ACT_PONG, 5'd7, 32'd11);

    // zero limits: fill every slot, then one sweep expires or re-pings all
    set_timing(32'd0, 32'd0);
    wait_drained();
    write_reg(CFG_IDX_SPARE, 32'hFFFF_FFFF);
    write_reg(CFG_IDX_TOP, 32'h0000_0000);
    clock_ms = 32'd5000;
    for (int s = 0; s < 32; s++) send_event(kst_pkg::ACT_CONNECT, 5'(s), clock_ms);
    send_event(kst_pkg::ACT_TICK, 5'd0, clock_ms + 32'd1);
    run_random(15, 32'd3);

    // never expire, ping whenever the pong is back and the age is not zero
    set_timing(32'hFFFF_FFFF, 32'd0);
    run_random(20, 32'd4);

    // expire on any delay, never re-ping
    set_timing(32'd0, 32'hFFFF_FFFF);
    run_random(15, 32'd4);

    // moderate random limits
    begin
      logic [31:0] wait_ms;
      logic [31:0] gap_ms;
      wait_ms = $urandom_range(50, 500);
      gap_ms  = $urandom_range(50, 500);
      set_timing(wait_ms, gap_ms);
      run_random(25, (wait_ms > gap_ms ? wait_ms : gap_ms) * 3);
    end

    // back to the reset values
    set_timing(kst_pkg::RESET_WAIT_MS, kst_pkg::RESET_INTERVAL_MS);
    run_random(20, 32'd25000);

    wait_drained();
    $display("covered %0d events (%0d sweeps) under %0d timing settings",
             events_sent, sweeps_sent, settings_used);
    $display("compared %0d result beats", beats_checked);
    if (errors == 0 && outstanding == 0) begin
      $display("[keepalive_session_table] OK");
    end else begin
      $display("[keepalive_session_table] ERROR");
    end
    $finish;
  end

endmodule
